// ===== rtl/i2cmrt_pkg.sv =====
// Package for the I2C master register transfer unit.
// Holds phase and role codes, command codes, status codes and the request/result types.
// No dependencies.
package i2cmrt_pkg;

    // Sequencer phases
    localparam logic [4:0] PH_IDLE        = 5'd0;
    localparam logic [4:0] PH_START_CHECK = 5'd1;
    localparam logic [4:0] PH_START_HOLD  = 5'd2;
    localparam logic [4:0] PH_START_CLAMP = 5'd3;
    localparam logic [4:0] PH_TX_DATA     = 5'd4;
    localparam logic [4:0] PH_TX_HIGH     = 5'd5;
    localparam logic [4:0] PH_TX_FALL     = 5'd6;
    localparam logic [4:0] PH_ACK_LOW     = 5'd7;
    localparam logic [4:0] PH_ACK_HIGH    = 5'd8;
    localparam logic [4:0] PH_ACK_FALL    = 5'd9;
    localparam logic [4:0] PH_FETCH       = 5'd10;
    localparam logic [4:0] PH_RS_SETUP    = 5'd11;
    localparam logic [4:0] PH_RS_HIGH     = 5'd12;
    localparam logic [4:0] PH_RX_LOW      = 5'd13;
    localparam logic [4:0] PH_RX_HIGH     = 5'd14;
    localparam logic [4:0] PH_MACK_LOW    = 5'd15;
    localparam logic [4:0] PH_MACK_HIGH   = 5'd16;
    localparam logic [4:0] PH_MACK_FALL   = 5'd17;
    localparam logic [4:0] PH_STOP_LOW    = 5'd18;
    localparam logic [4:0] PH_STOP_HIGH   = 5'd19;

    // Which byte was just sent
    localparam logic [1:0] ROLE_ADDR_W = 2'd0;
    localparam logic [1:0] ROLE_REG    = 2'd1;
    localparam logic [1:0] ROLE_ADDR_R = 2'd2;
    localparam logic [1:0] ROLE_DATA   = 2'd3;

    // Commands
    localparam logic [1:0] OP_REG_WRITE   = 2'd0;
    localparam logic [1:0] OP_REG_READ    = 2'd1;
    localparam logic [1:0] OP_DIRECT_READ = 2'd2;
    localparam logic [1:0] OP_UNDEFINED   = 2'd3;

    // Status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_BUSY   = 2'd1;
    localparam logic [1:0] ST_NO_ACK = 2'd2;

    // Configuration
    localparam int unsigned TIMEOUT_W = 10;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 10'd250;
    localparam logic [0:0] REG_ACK_TIMEOUT = 1'b0;

    // Stream widths
    localparam int unsigned IN_TDATA_W  = 40;
    localparam int unsigned OUT_TDATA_W = 16;

    // One input tick (first member is the top bit)
    typedef struct packed {
        logic       repeated_start;
        logic [7:0] write_byte;
        logic [7:0] byte_count;
        logic [7:0] register_address;
        logic [6:0] slave_address;
        logic [1:0] operation;
        logic       start_request;
        logic       sda_in;
    } t_in_item;

    // One result tick, packed as on the output tdata
    typedef struct packed {
        logic [1:0] status;
        logic       transfer_done;
        logic       read_byte_valid;
        logic [7:0] read_byte;
        logic       byte_request;
        logic       sda_output_enable;
        logic       sda_out;
        logic       scl;
    } t_result;

endpackage

// ===== rtl/i2c_master_register_transfer_unit.sv =====
// Top level of the I2C master register transfer unit.
// Instantiates i2cmrt_cfg, i2cmrt_seq and i2cmrt_out; depends on i2cmrt_pkg.
//
// Bit-banged I2C master for register writes, register reads (with or without
// repeated start) and direct reads. Each input request is one bus tick carrying
// the sampled data line and the command; each tick yields exactly one result
// with the line drive for the next tick, byte requests, received bytes and the
// end-of-transfer status. One request is taken per clock cycle: the sequencer
// state updates in the cycle of acceptance and the result lands in a single
// output register, valid in the cycle after acceptance; the unit only pauses
// while that output register is full and not being drained. The acknowledge
// timeout is set through the APB port at address 0 (reset 250).
module i2c_master_register_transfer_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input ticks
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [0] sda_in, [1] start_request, [8:2] slave_address, [16:9] register_address,
    // [24:17] byte_count, [32:25] write_byte, [33] repeated_start, [39:34] zero
    input  logic [i2cmrt_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // [1:0] operation
    input  logic [1:0]  s_axis_tuser,
    // results
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [0] scl, [1] sda_out, [2] sda_output_enable, [3] byte_request, [11:4] read_byte,
    // [12] read_byte_valid, [13] transfer_done, [15:14] status
    output logic [i2cmrt_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import i2cmrt_pkg::*;

    logic [TIMEOUT_W-1:0] ack_timeout;
    t_in_item             item;
    t_result              seq_result;
    t_result              out_result;
    logic                 accept;
    logic                 out_free;

    // Unpack the request
    always_comb begin
        item                  = '0;
        item.sda_in           = s_axis_tdata[0];
        item.start_request    = s_axis_tdata[1];
        item.operation        = s_axis_tuser;
        item.slave_address    = s_axis_tdata[8:2];
        item.register_address = s_axis_tdata[16:9];
        item.byte_count       = s_axis_tdata[24:17];
        item.write_byte       = s_axis_tdata[32:25];
        item.repeated_start   = s_axis_tdata[33];
    end

    assign s_axis_tready = out_free;
    assign accept        = s_axis_tvalid && s_axis_tready;

    i2cmrt_cfg u_cfg (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .o_ack_timeout (ack_timeout)
    );

    i2cmrt_seq u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_item        (item),
        .i_ack_timeout (ack_timeout),
        .o_result      (seq_result)
    );

    i2cmrt_out u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (accept),
        .i_result (seq_result),
        .i_taken  (m_axis_tready),
        .o_free   (out_free),
        .o_valid  (m_axis_tvalid),
        .o_result (out_result)
    );

    assign m_axis_tdata = out_result;

    // A nonzero status only comes with the end of a transfer
    a_status_with_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (out_result.status != ST_OK)) |-> out_result.transfer_done)
        else $error("status reported without transfer_done");

    // A released data line always comes with sda_out high
    a_release_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !out_result.sda_output_enable) |-> out_result.sda_out)
        else $error("sda_out low while released");

    // Input side stalls only because a result is waiting downstream
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
        else $error("input stalled without a pending result");

    // Every accepted tick produces a result in the next cycle
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> m_axis_tvalid)
        else $error("accepted tick produced no result");

    // A received byte never coincides with a byte request
    a_rx_tx_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(out_result.read_byte_valid && out_result.byte_request))
        else $error("read byte and byte request in one tick");

endmodule

// ===== rtl/i2cmrt_cfg.sv =====
// APB-style configuration register bank for the I2C master register transfer unit.
// Holds the acknowledge timeout. Depends on i2cmrt_pkg.
module i2cmrt_cfg (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [2:0]                       paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready,
    output logic [i2cmrt_pkg::TIMEOUT_W-1:0] o_ack_timeout
);
    import i2cmrt_pkg::*;

    logic [TIMEOUT_W-1:0] r_ack_timeout;
    logic                 hit;

    assign hit    = (paddr[2] == REG_ACK_TIMEOUT);
    assign pready = 1'b1;

    // Register write on the access cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ack_timeout <= TIMEOUT_RESET;
        end else if (psel && penable && pwrite && pready && hit) begin
            r_ack_timeout <= pwdata[TIMEOUT_W-1:0];
        end
    end

    // Read-back
    always_comb begin
        prdata = 32'd0;
        if (hit) begin
            prdata = {{(32-TIMEOUT_W){1'b0}}, r_ack_timeout};
        end
    end

    assign o_ack_timeout = r_ack_timeout;

endmodule

// ===== rtl/i2cmrt_seq.sv =====
// Bus sequencer of the I2C master register transfer unit: state registers,
// one-tick next-state logic and line drive. Depends on i2cmrt_pkg.
module i2cmrt_seq (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_accept,
    input  i2cmrt_pkg::t_in_item             i_item,
    input  logic [i2cmrt_pkg::TIMEOUT_W-1:0] i_ack_timeout,
    output i2cmrt_pkg::t_result              o_result
);
    import i2cmrt_pkg::*;

    logic [4:0]           r_phase,     n_phase;
    logic [2:0]           r_bit_cnt,   n_bit_cnt;
    logic [7:0]           r_shift,     n_shift;
    logic [7:0]           r_left,      n_left;
    logic [TIMEOUT_W-1:0] r_wait,      n_wait;
    logic [1:0]           r_op,        n_op;
    logic [6:0]           r_addr,      n_addr;
    logic [7:0]           r_reg,       n_reg;
    logic                 r_restart,   n_restart;
    logic [1:0]           r_role,      n_role;
    logic [1:0]           r_outcome,   n_outcome;

    logic       req;
    logic       rvalid;
    logic [7:0] rbyte;
    logic       done;
    logic [1:0] status;
    logic       drv_bit;
    logic       mack_bit;

    // Next state for one bus tick
    always_comb begin
        n_phase   = r_phase;
        n_bit_cnt = r_bit_cnt;
        n_shift   = r_shift;
        n_left    = r_left;
        n_wait    = r_wait;
        n_op      = r_op;
        n_addr    = r_addr;
        n_reg     = r_reg;
        n_restart = r_restart;
        n_role    = r_role;
        n_outcome = r_outcome;
        req       = 1'b0;
        rvalid    = 1'b0;
        rbyte     = 8'd0;
        done      = 1'b0;
        status    = ST_OK;
        case (r_phase)
            PH_IDLE: begin
                if (i_item.start_request && (i_item.operation != OP_UNDEFINED)) begin
                    n_op      = i_item.operation;
                    n_addr    = i_item.slave_address;
                    n_reg     = i_item.register_address;
                    n_restart = i_item.repeated_start;
                    n_left    = ((i_item.operation != OP_REG_WRITE) &&
                                 (i_item.byte_count == 8'd0)) ? 8'd1 : i_item.byte_count;
                    n_outcome = ST_OK;
                    n_phase   = PH_START_CHECK;
                end
            end
            PH_START_CHECK: begin
                if (!i_item.sda_in) begin
                    done    = 1'b1;
                    status  = ST_BUSY;
                    n_phase = PH_IDLE;
                end else begin
                    n_bit_cnt = 3'd0;
                    if (r_op == OP_DIRECT_READ) begin
                        n_shift = {r_addr, 1'b1};
                        n_role  = ROLE_ADDR_R;
                    end else begin
                        n_shift = {r_addr, 1'b0};
                        n_role  = ROLE_ADDR_W;
                    end
                    n_phase = PH_START_HOLD;
                end
            end
            PH_START_HOLD:  n_phase = PH_START_CLAMP;
            PH_START_CLAMP: n_phase = PH_TX_DATA;
            PH_TX_DATA:     n_phase = PH_TX_HIGH;
            PH_TX_HIGH:     n_phase = PH_TX_FALL;
            PH_TX_FALL: begin
                if (r_bit_cnt == 3'd7) begin
                    n_phase = PH_ACK_LOW;
                end else begin
                    n_shift   = {r_shift[6:0], 1'b0};
                    n_bit_cnt = r_bit_cnt + 3'd1;
                    n_phase   = PH_TX_DATA;
                end
            end
            PH_ACK_LOW: begin
                n_wait  = '0;
                n_phase = PH_ACK_HIGH;
            end
            PH_ACK_HIGH: begin
                if (!i_item.sda_in) begin
                    n_phase = PH_ACK_FALL;
                end else if (r_wait >= i_ack_timeout) begin
                    n_outcome = ST_NO_ACK;
                    n_phase   = PH_ACK_FALL;
                end else begin
                    n_wait = r_wait + 1'b1;
                end
            end
            PH_ACK_FALL: begin
                if (r_outcome != ST_OK) begin
                    n_phase = PH_STOP_LOW;
                end else if (r_role == ROLE_ADDR_W) begin
                    n_shift   = r_reg;
                    n_role    = ROLE_REG;
                    n_bit_cnt = 3'd0;
                    n_phase   = PH_TX_DATA;
                end else if ((r_role == ROLE_REG) && (r_op != OP_REG_WRITE)) begin
                    if (r_restart) begin
                        n_phase = PH_RS_SETUP;
                    end else begin
                        n_shift   = {r_addr, 1'b1};
                        n_role    = ROLE_ADDR_R;
                        n_bit_cnt = 3'd0;
                        n_phase   = PH_TX_DATA;
                    end
                end else if ((r_role == ROLE_REG) || (r_role == ROLE_DATA)) begin
                    // register write: same path after register byte and data bytes
                    if (r_left != 8'd0) begin
                        n_left  = r_left - 8'd1;
                        req     = 1'b1;
                        n_phase = PH_FETCH;
                    end else begin
                        n_phase = PH_STOP_LOW;
                    end
                end else begin
                    // read address acknowledged
                    n_shift   = 8'd0;
                    n_bit_cnt = 3'd0;
                    n_phase   = PH_RX_LOW;
                end
            end
            PH_FETCH: begin
                n_shift   = i_item.write_byte;
                n_role    = ROLE_DATA;
                n_bit_cnt = 3'd0;
                n_phase   = PH_TX_DATA;
            end
            PH_RS_SETUP: n_phase = PH_RS_HIGH;
            PH_RS_HIGH: begin
                n_shift   = {r_addr, 1'b1};
                n_role    = ROLE_ADDR_R;
                n_bit_cnt = 3'd0;
                n_phase   = PH_START_HOLD;
            end
            PH_RX_LOW: n_phase = PH_RX_HIGH;
            PH_RX_HIGH: begin
                n_shift = {r_shift[6:0], i_item.sda_in};
                if (r_bit_cnt == 3'd7) begin
                    rbyte   = n_shift;
                    rvalid  = 1'b1;
                    n_phase = PH_MACK_LOW;
                end else begin
                    n_bit_cnt = r_bit_cnt + 3'd1;
                    n_phase   = PH_RX_LOW;
                end
            end
            PH_MACK_LOW:  n_phase = PH_MACK_HIGH;
            PH_MACK_HIGH: n_phase = PH_MACK_FALL;
            PH_MACK_FALL: begin
                if (r_left > 8'd1) begin
                    n_left    = r_left - 8'd1;
                    n_shift   = 8'd0;
                    n_bit_cnt = 3'd0;
                    n_phase   = PH_RX_LOW;
                end else begin
                    n_phase = PH_STOP_LOW;
                end
            end
            PH_STOP_LOW: n_phase = PH_STOP_HIGH;
            PH_STOP_HIGH: begin
                done      = 1'b1;
                status    = r_outcome;
                n_outcome = ST_OK;
                n_phase   = PH_IDLE;
            end
            default: n_phase = PH_IDLE;
        endcase
    end

    // Line drive for the coming tick, from the new state
    assign drv_bit  = n_shift[7];
    assign mack_bit = (n_left > 8'd1) ? 1'b0 : 1'b1;

    always_comb begin
        o_result                   = '0;
        o_result.scl               = 1'b0;
        o_result.sda_out           = 1'b1;
        o_result.sda_output_enable = 1'b1;
        case (n_phase)
            PH_START_HOLD: begin
                o_result.scl     = 1'b1;
                o_result.sda_out = 1'b0;
            end
            PH_START_CLAMP: o_result.sda_out = 1'b0;
            PH_TX_DATA, PH_TX_FALL: o_result.sda_out = drv_bit;
            PH_TX_HIGH: begin
                o_result.scl     = 1'b1;
                o_result.sda_out = drv_bit;
            end
            PH_ACK_LOW, PH_ACK_FALL, PH_FETCH, PH_RX_LOW: begin
                o_result.sda_output_enable = 1'b0;
            end
            PH_ACK_HIGH, PH_RX_HIGH: begin
                o_result.scl               = 1'b1;
                o_result.sda_output_enable = 1'b0;
            end
            PH_RS_SETUP: o_result.scl = 1'b0;
            PH_MACK_LOW, PH_MACK_FALL: o_result.sda_out = mack_bit;
            PH_MACK_HIGH: begin
                o_result.scl     = 1'b1;
                o_result.sda_out = mack_bit;
            end
            PH_STOP_LOW: o_result.sda_out = 1'b0;
            PH_STOP_HIGH: begin
                o_result.scl     = 1'b1;
                o_result.sda_out = 1'b0;
            end
            default: o_result.scl = 1'b1; // idle, start check, restart high
        endcase
        o_result.byte_request    = req;
        o_result.read_byte       = rbyte;
        o_result.read_byte_valid = rvalid;
        o_result.transfer_done   = done;
        o_result.status          = status;
    end

    // State registers advance once per accepted tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_bit_cnt <= 3'd0;
            r_shift   <= 8'd0;
            r_left    <= 8'd0;
            r_wait    <= '0;
            r_op      <= OP_REG_WRITE;
            r_addr    <= 7'd0;
            r_reg     <= 8'd0;
            r_restart <= 1'b0;
            r_role    <= ROLE_ADDR_W;
            r_outcome <= ST_OK;
        end else if (i_accept) begin
            r_phase   <= n_phase;
            r_bit_cnt <= n_bit_cnt;
            r_shift   <= n_shift;
            r_left    <= n_left;
            r_wait    <= n_wait;
            r_op      <= n_op;
            r_addr    <= n_addr;
            r_reg     <= n_reg;
            r_restart <= n_restart;
            r_role    <= n_role;
            r_outcome <= n_outcome;
        end
    end

endmodule

// ===== rtl/i2cmrt_out.sv =====
// Output register stage of the I2C master register transfer unit.
// Holds one result while the downstream side stalls. Depends on i2cmrt_pkg.
module i2cmrt_out (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  i2cmrt_pkg::t_result i_result,
    input  logic                i_taken,
    output logic                o_free,
    output logic                o_valid,
    output i2cmrt_pkg::t_result o_result
);
    import i2cmrt_pkg::*;

    logic    r_valid;
    t_result r_result;

    // Stage can take a new result when empty or being drained
    assign o_free = !r_valid || i_taken;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_taken) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

// ===== sim/i2c_master_register_transfer_unit_tb.sv =====
// Testbench for the I2C master register transfer unit: a bus model feeds ticks,
// a scoreboard class predicts each result tick and checks the output stream.
// Depends on i2cmrt_pkg and i2c_master_register_transfer_unit.
`timescale 1ns / 1ps

module i2c_master_register_transfer_unit_tb;

    import i2cmrt_pkg::*;

    localparam int WATCHDOG_LIMIT     = 3000;
    localparam int FORCED_NACK_TICKS  = 1100;   // longer than any 10-bit timeout
    localparam int SETTLE_CYCLES      = 4;
    localparam logic [2:0] ACK_TIMEOUT_ADDR = 3'(4 * REG_ACK_TIMEOUT);

    // One transaction as the bus model issues it
    typedef struct {
        logic [1:0] op;
        logic [6:0] slave_address;
        logic [7:0] register_address;
        logic [7:0] byte_count;
        logic       repeated_start;
        bit         bus_busy;
        int         nack_at;        // ack window to time out, -1 for none
    } t_txn;

    // Predicts line drive and reports per tick and checks them in order
    class line_drive_scoreboard;
        logic [4:0]           phase;
        logic [2:0]           bit_cnt;
        logic [7:0]           shreg;
        logic [7:0]           bytes_left;
        logic [TIMEOUT_W-1:0] ack_wait;
        logic [TIMEOUT_W-1:0] ack_timeout;
        logic [1:0]           cmd_op;
        logic [6:0]           cmd_addr;
        logic [7:0]           cmd_reg;
        logic                 cmd_rs;
        logic [1:0]           role;
        logic [1:0]           outcome;
        t_result              expected_drive_q[$];
        int                   errors;
        int                   transfers;
        int                   rx_bytes;
        int                   no_acks;
        int                   busy_ends;

        function new();
            ack_timeout = TIMEOUT_RESET;
            phase       = PH_IDLE;
            bit_cnt     = '0;
            shreg       = '0;
            bytes_left  = '0;
            ack_wait    = '0;
            cmd_op      = OP_REG_WRITE;
            cmd_addr    = '0;
            cmd_reg     = '0;
            cmd_rs      = 1'b0;
            role        = ROLE_ADDR_W;
            outcome     = ST_OK;
            errors      = 0;
            transfers   = 0;
            rx_bytes    = 0;
            no_acks     = 0;
            busy_ends   = 0;
        endfunction

        function void set_timeout(logic [TIMEOUT_W-1:0] v);
            ack_timeout = v;
        endfunction

        function void load_byte(logic [7:0] b, logic [1:0] r);
            shreg   = b;
            role    = r;
            bit_cnt = '0;
        endfunction

        // Advance the sequencer by one accepted tick and queue its result
        function void note_tick(t_in_item t);
            t_result r;
            logic    b;
            logic    a;
            r = '0;
            case (phase)
                PH_IDLE: begin
                    if (t.start_request && t.operation != OP_UNDEFINED) begin
                        cmd_op     = t.operation;
                        cmd_addr   = t.slave_address;
                        cmd_reg    = t.register_address;
                        cmd_rs     = t.repeated_start;
                        bytes_left = (t.operation != OP_REG_WRITE && t.byte_count == 0) ?
                                     8'd1 : t.byte_count;
                        outcome    = ST_OK;
                        phase      = PH_START_CHECK;
                    end
                end
                PH_START_CHECK: begin
                    if (!t.sda_in) begin
                        r.transfer_done = 1'b1;
                        r.status        = ST_BUSY;
                        phase           = PH_IDLE;
                        busy_ends++;
                    end else begin
                        if (cmd_op == OP_DIRECT_READ) load_byte({cmd_addr, 1'b1}, ROLE_ADDR_R);
                        else load_byte({cmd_addr, 1'b0}, ROLE_ADDR_W);
                        phase = PH_START_HOLD;
                    end
                end
                PH_START_HOLD:  phase = PH_START_CLAMP;
                PH_START_CLAMP: phase = PH_TX_DATA;
                PH_TX_DATA:     phase = PH_TX_HIGH;
                PH_TX_HIGH:     phase = PH_TX_FALL;
                PH_TX_FALL: begin
                    if (bit_cnt == 3'd7) begin
                        phase = PH_ACK_LOW;
                    end else begin
                        shreg   = {shreg[6:0], 1'b0};
                        bit_cnt = bit_cnt + 3'd1;
                        phase   = PH_TX_DATA;
                    end
                end
                PH_ACK_LOW: begin
                    ack_wait = '0;
                    phase    = PH_ACK_HIGH;
                end
                PH_ACK_HIGH: begin
                    if (!t.sda_in) begin
                        phase = PH_ACK_FALL;
                    end else if (ack_wait >= ack_timeout) begin
                        outcome = ST_NO_ACK;
                        phase   = PH_ACK_FALL;
                        no_acks++;
                    end else begin
                        ack_wait = ack_wait + 1'b1;
                    end
                end
                PH_ACK_FALL: begin
                    if (outcome != ST_OK) begin
                        phase = PH_STOP_LOW;
                    end else if (role == ROLE_ADDR_W) begin
                        load_byte(cmd_reg, ROLE_REG);
                        phase = PH_TX_DATA;
                    end else if (role == ROLE_ADDR_R) begin
                        shreg   = '0;
                        bit_cnt = '0;
                        phase   = PH_RX_LOW;
                    end else if (role == ROLE_REG && cmd_op != OP_REG_WRITE) begin
                        if (cmd_rs) begin
                            phase = PH_RS_SETUP;
                        end else begin
                            load_byte({cmd_addr, 1'b1}, ROLE_ADDR_R);
                            phase = PH_TX_DATA;
                        end
                    end else if (bytes_left != 0) begin
                        // register byte of a write, or a data byte: fetch the next one
                        bytes_left     = bytes_left - 8'd1;
                        r.byte_request = 1'b1;
                        phase          = PH_FETCH;
                    end else begin
                        phase = PH_STOP_LOW;
                    end
                end
                PH_FETCH: begin
                    load_byte(t.write_byte, ROLE_DATA);
                    phase = PH_TX_DATA;
                end
                PH_RS_SETUP: phase = PH_RS_HIGH;
                PH_RS_HIGH: begin
                    load_byte({cmd_addr, 1'b1}, ROLE_ADDR_R);
                    phase = PH_START_HOLD;
                end
                PH_RX_LOW: phase = PH_RX_HIGH;
                PH_RX_HIGH: begin
                    shreg = {shreg[6:0], t.sda_in};
                    if (bit_cnt == 3'd7) begin
                        r.read_byte       = shreg;
                        r.read_byte_valid = 1'b1;
                        phase             = PH_MACK_LOW;
                        rx_bytes++;
                    end else begin
                        bit_cnt = bit_cnt + 3'd1;
                        phase   = PH_RX_LOW;
                    end
                end
                PH_MACK_LOW:  phase = PH_MACK_HIGH;
                PH_MACK_HIGH: phase = PH_MACK_FALL;
                PH_MACK_FALL: begin
                    if (bytes_left > 8'd1) begin
                        bytes_left = bytes_left - 8'd1;
                        shreg      = '0;
                        bit_cnt    = '0;
                        phase      = PH_RX_LOW;
                    end else begin
                        phase = PH_STOP_LOW;
                    end
                end
                PH_STOP_LOW: phase = PH_STOP_HIGH;
                PH_STOP_HIGH: begin
                    r.transfer_done = 1'b1;
                    r.status        = outcome;
                    outcome         = ST_OK;
                    phase           = PH_IDLE;
                    transfers++;
                end
                default: phase = PH_IDLE;
            endcase

            // line drive for the next tick, from the new state
            b = shreg[7];
            a = (bytes_left > 8'd1) ? 1'b0 : 1'b1;
            r.scl               = 1'b0;
            r.sda_out           = 1'b1;
            r.sda_output_enable = 1'b1;
            case (phase)
                PH_START_HOLD:  begin r.scl = 1'b1; r.sda_out = 1'b0; end
                PH_START_CLAMP: r.sda_out = 1'b0;
                PH_TX_DATA, PH_TX_FALL: r.sda_out = b;
                PH_TX_HIGH:     begin r.scl = 1'b1; r.sda_out = b; end
                PH_ACK_LOW, PH_ACK_FALL, PH_FETCH, PH_RX_LOW: r.sda_output_enable = 1'b0;
                PH_ACK_HIGH, PH_RX_HIGH: begin
                    r.scl               = 1'b1;
                    r.sda_output_enable = 1'b0;
                end
                PH_RS_SETUP: ;
                PH_MACK_LOW, PH_MACK_FALL: r.sda_out = a;
                PH_MACK_HIGH:   begin r.scl = 1'b1; r.sda_out = a; end
                PH_STOP_LOW:    r.sda_out = 1'b0;
                PH_STOP_HIGH:   begin r.scl = 1'b1; r.sda_out = 1'b0; end
                default:        r.scl = 1'b1;
            endcase
            expected_drive_q.push_back(r);
        endfunction

        function void compare_field(string name, int unsigned exp_v, int unsigned act_v);
            if (exp_v != act_v) begin
                $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
                errors++;
            end
        endfunction

        function void check_drive(t_result got);
            t_result exp_r;
            if (expected_drive_q.size() == 0) begin
                $error("result with no request outstanding: %h", got);
                errors++;
                return;
            end
            exp_r = expected_drive_q.pop_front();
            compare_field("scl", exp_r.scl, got.scl);
            compare_field("sda_out", exp_r.sda_out, got.sda_out);
            compare_field("sda_output_enable", exp_r.sda_output_enable, got.sda_output_enable);
            compare_field("byte_request", exp_r.byte_request, got.byte_request);
            compare_field("read_byte", exp_r.read_byte, got.read_byte);
            compare_field("read_byte_valid", exp_r.read_byte_valid, got.read_byte_valid);
            compare_field("transfer_done", exp_r.transfer_done, got.transfer_done);
            compare_field("status", exp_r.status, got.status);
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    // [0] sda_in, [1] start_request, [8:2] slave_address, [16:9] register_address,
    // [24:17] byte_count, [32:25] write_byte, [33] repeated_start, [39:34] zero
    logic [39:0] s_axis_tdata;
    // [1:0] operation
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    // [0] scl, [1] sda_out, [2] sda_output_enable, [3] byte_request, [11:4] read_byte,
    // [12] read_byte_valid, [13] transfer_done, [15:14] status
    logic [15:0] m_axis_tdata;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    line_drive_scoreboard sb;
    bit  steady_flow;       // no idling on either side while set
    int  nack_pct;          // chance per ack window of a forced timeout
    int  ack_idx;
    int  ack_delay;
    int  tick_count;
    int  idle_cycles;
    int  settings_used;

    i2c_master_register_transfer_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Output back-pressure
    initial begin
        m_axis_tready = 1'b1;
        forever begin
            @(negedge i_clk);
            m_axis_tready = steady_flow || ($urandom_range(99) >= 25);
        end
    end

    // Monitor: feed accepted requests to the predictor, check results, watchdog
    always @(posedge i_clk) begin
        t_in_item t;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready)
                sb.check_drive(t_result'(m_axis_tdata));
            if (s_axis_tvalid && s_axis_tready) begin
                t.sda_in           = s_axis_tdata[0];
                t.start_request    = s_axis_tdata[1];
                t.slave_address    = s_axis_tdata[8:2];
                t.register_address = s_axis_tdata[16:9];
                t.byte_count       = s_axis_tdata[24:17];
                t.write_byte       = s_axis_tdata[32:25];
                t.repeated_start   = s_axis_tdata[33];
                t.operation        = s_axis_tuser;
                sb.note_tick(t);
            end
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles = idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Timeout: no request or result moved for %0d cycles", idle_cycles);
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // Present one tick and hold it until accepted; returns on a falling edge
    task automatic send_tick(t_in_item t);
        while (!steady_flow && $urandom_range(99) < 25) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {6'b0, t.repeated_start, t.write_byte, t.byte_count,
                         t.register_address, t.slave_address, t.start_request, t.sda_in};
        s_axis_tuser  = t.operation;
        do @(posedge i_clk); while (!s_axis_tready);
        tick_count++;
        @(negedge i_clk);
    endtask

    // Slave side of the bus: level seen on the data line for the coming tick
    function automatic t_in_item next_tick(t_txn c, bit first);
        t_in_item t;
        int       r;
        t.sda_in           = 1'($urandom_range(1));
        t.start_request    = 1'($urandom_range(1));
        t.operation        = 2'($urandom_range(3));
        t.slave_address    = 7'($urandom_range(127));
        t.register_address = 8'($urandom_range(255));
        t.byte_count       = 8'($urandom_range(255));
        t.write_byte       = 8'($urandom_range(255));
        t.repeated_start   = 1'($urandom_range(1));
        if (first) begin
            t.start_request    = 1'b1;
            t.operation        = c.op;
            t.slave_address    = c.slave_address;
            t.register_address = c.register_address;
            t.byte_count       = c.byte_count;
            t.repeated_start   = c.repeated_start;
            return t;
        end
        case (sb.phase)
            PH_START_CHECK: t.sda_in = !c.bus_busy;
            PH_ACK_LOW: begin
                r = $urandom_range(99);
                if (ack_idx == c.nack_at || r < nack_pct) ack_delay = FORCED_NACK_TICKS;
                else if (r < nack_pct + 15) ack_delay = $urandom_range(3, 1);
                else ack_delay = 0;
                ack_idx++;
            end
            PH_ACK_HIGH: begin
                t.sda_in = (ack_delay > 0);
                if (ack_delay > 0) ack_delay--;
            end
            default: ;
        endcase
        return t;
    endfunction

    task automatic run_txn(t_txn c);
        bit first;
        first   = 1'b1;
        ack_idx = 0;
        do begin
            send_tick(next_tick(c, first));
            first = 1'b0;
        end while (sb.phase != PH_IDLE);
    endtask

    function automatic t_txn make_txn(logic [1:0] op, logic [6:0] sa, logic [7:0] ra,
                                      logic [7:0] cnt, logic rs, bit busy, int nack_at);
        t_txn c;
        c.op               = op;
        c.slave_address    = sa;
        c.register_address = ra;
        c.byte_count       = cnt;
        c.repeated_start   = rs;
        c.bus_busy         = busy;
        c.nack_at          = nack_at;
        return c;
    endfunction

    // Ticks with nothing to start: start requests only with the undefined code
    task automatic idle_ticks(int n);
        t_in_item t;
        t_txn     c;
        c = make_txn(OP_UNDEFINED, 7'd0, 8'd0, 8'd0, 1'b0, 1'b0, -1);
        repeat (n) begin
            t = next_tick(c, 1'b0);
            if (t.start_request) t.operation = OP_UNDEFINED;
            send_tick(t);
        end
    endtask

    function automatic t_txn random_txn();
        int   sel;
        logic [7:0] cnt;
        sel = $urandom_range(99);
        if (sel < 75) cnt = 8'($urandom_range(4));
        else          cnt = 8'($urandom_range(12, 5));
        return make_txn(($urandom_range(99) < 3) ? OP_UNDEFINED : 2'($urandom_range(2)),
                        7'($urandom_range(127)), 8'($urandom_range(255)), cnt,
                        1'($urandom_range(1)), $urandom_range(99) < 5, -1);
    endfunction

    task automatic run_random(int n_ticks);
        int stop_at;
        stop_at = tick_count + n_ticks;
        while (tick_count < stop_at) begin
            run_txn(random_txn());
            if ($urandom_range(3) == 0) idle_ticks($urandom_range(3, 1));
        end
    endtask

    // Let every expected result arrive, then let the outputs settle
    task automatic drain();
        s_axis_tvalid = 1'b0;
        while (sb.expected_drive_q.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // APB write of the acknowledge timeout, then read it back
    task automatic set_ack_timeout(logic [TIMEOUT_W-1:0] v);
        logic [31:0] rd;
        drain();
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = ACK_TIMEOUT_ADDR;
        pwdata  = 32'(v);
        @(negedge i_clk);
        penable = 1'b1;
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        sb.set_timeout(v);
        @(negedge i_clk);
        psel = 1'b1;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        rd = prdata;
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        if (rd != 32'(v)) begin
            $error("ack_timeout readback mismatch: expected %0d, got %0d", v, rd);
            sb.errors++;
        end
        settings_used++;
    endtask

    // Stimulus
    initial begin
        t_txn dir_q[$];
        t_txn nack_q[$];
        sb            = new();
        steady_flow   = 1'b0;
        nack_pct      = 0;
        ack_idx       = 0;
        ack_delay     = 0;
        tick_count    = 0;
        idle_cycles   = 0;
        settings_used = 1;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = OP_REG_WRITE;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = ACK_TIMEOUT_ADDR;
        pwdata        = '0;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Directed at the reset timeout: every command, field extremes, bus busy, address nack
        dir_q.push_back(make_txn(OP_REG_WRITE, 7'd0, 8'd0, 8'd0, 1'b0, 1'b0, -1));     // empty
        dir_q.push_back(make_txn(OP_REG_WRITE, 7'd127, 8'd255, 8'd1, 1'b1, 1'b0, -1));
        dir_q.push_back(make_txn(OP_REG_WRITE, 7'h55, 8'hAA, 8'd3, 1'b0, 1'b0, -1));
        dir_q.push_back(make_txn(OP_REG_READ, 7'd127, 8'd0, 8'd0, 1'b1, 1'b0, -1));    // one
        dir_q.push_back(make_txn(OP_REG_READ, 7'h2A, 8'h5A, 8'd2, 1'b0, 1'b0, -1));    // no rs
        dir_q.push_back(make_txn(OP_DIRECT_READ, 7'd0, 8'd0, 8'd1, 1'b0, 1'b0, -1));
        dir_q.push_back(make_txn(OP_REG_WRITE, 7'h12, 8'h34, 8'd2, 1'b0, 1'b1, -1));   // busy
        dir_q.push_back(make_txn(OP_DIRECT_READ, 7'h33, 8'd0, 8'd4, 1'b0, 1'b1, -1));
        dir_q.push_back(make_txn(OP_UNDEFINED, 7'h7F, 8'hFF, 8'd5, 1'b1, 1'b0, -1));   // ignored
        dir_q.push_back(make_txn(OP_REG_WRITE, 7'h50, 8'h01, 8'd2, 1'b0, 1'b0, 0));    // addr nack
        foreach (dir_q[i]) begin
            run_txn(dir_q[i]);
            idle_ticks(1);
        end

        // Missing acks at every byte position, under a short timeout
        nack_q.push_back(make_txn(OP_REG_READ, 7'h51, 8'h02, 8'd1, 1'b1, 1'b0, 1));     // reg
        nack_q.push_back(make_txn(OP_REG_READ, 7'h52, 8'h03, 8'd1, 1'b1, 1'b0, 2));     // rd addr
        nack_q.push_back(make_txn(OP_REG_WRITE, 7'h53, 8'h04, 8'd255, 1'b0, 1'b0, 3));  // data
        nack_q.push_back(make_txn(OP_DIRECT_READ, 7'h54, 8'd0, 8'd0, 1'b0, 1'b0, 0));
        nack_q.push_back(make_txn(OP_DIRECT_READ, 7'h7E, 8'd0, 8'd255, 1'b0, 1'b0, 0)); // max
        set_ack_timeout(10'd4);
        foreach (nack_q[i]) begin
            run_txn(nack_q[i]);
            idle_ticks(1);
        end

        // Random traffic across timeout settings, 1 and the 10-bit maximum among them
        nack_pct = 3;
        set_ack_timeout(10'd1);
        run_random(150);
        set_ack_timeout(10'd1023);
        steady_flow = 1'b1;
        nack_pct    = 0;
        run_random(150);
        steady_flow = 1'b0;
        nack_pct    = 3;
        set_ack_timeout(10'($urandom_range(40, 2)));
        run_random(150);
        set_ack_timeout(TIMEOUT_RESET);
        nack_pct = 0;
        run_random(100);
        drain();

        $display("Covered %0d ticks over %0d timeout settings: %0d transfers, %0d bytes read,",
                 tick_count, settings_used, sb.transfers, sb.rx_bytes);
        $display("%0d acknowledge timeouts and %0d busy-bus aborts.", sb.no_acks, sb.busy_ends);
        if (sb.errors == 0 && sb.expected_drive_q.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
